### rtl/sei_pkg.sv
// shared constants, types and tables for the sine ease-in/ease-out profile
// no dependencies; imported by every module of the block
package sei_pkg;

  // interface fraction format and internal q30 format
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned FW        = FRAC_BITS + 1;
  localparam int unsigned Q         = 30;
  localparam int unsigned QW        = Q + 1;
  localparam int unsigned SW        = 32;
  localparam int unsigned NW        = SW + FRAC_BITS;
  localparam int unsigned CW        = 30;

  localparam logic [FW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [QW-1:0] QONE = {1'b1, {Q{1'b0}}};

  // 2/pi in q30
  localparam logic [CW-1:0] TWO_OVER_PI = 30'd683565276;

  // taylor coefficients of sin(u*pi/2), q30, lowest order first
  localparam int unsigned SIN_TERMS = 7;
  localparam int unsigned SIN_STG   = SIN_TERMS + 1;
  localparam logic [QW-1:0] SIN_COEF [SIN_TERMS] = '{
    31'd1686629713, 31'd693598668, 31'd85569306, 31'd5027008,
    31'd172272, 31'd3864, 31'd61
  };

  // fractional divider: quotient bits and steps per stage
  localparam int unsigned DIV_STEPS = QW;
  localparam int unsigned DIV_SPS   = 4;
  localparam int unsigned DIV_STG   = (DIV_STEPS + DIV_SPS - 1) / DIV_SPS;

  // final normalising divider
  localparam int unsigned FIN_STEPS = FW;
  localparam int unsigned FIN_SPS   = 2;
  localparam int unsigned FIN_STG   = (FIN_STEPS + FIN_SPS - 1) / FIN_SPS;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_END   = 1'b0,
    CFG_DECEL_START = 1'b1
  } cfg_idx_e;

  // profile piece of an item
  typedef enum logic [1:0] {
    PH_EASE_IN  = 2'd0,
    PH_LINEAR   = 2'd1,
    PH_END      = 2'd2,
    PH_EASE_OUT = 2'd3
  } phase_e;

  // per-item sideband carried down the pipeline
  typedef struct packed {
    phase_e          phase;
    logic [FW-1:0]   t;
  } sei_side_t;

  // derived configuration: user keeps constant while items are in flight
  typedef struct packed {
    logic [FW-1:0] k1;
    logic [FW-1:0] k2;
    logic [QW-1:0] k1s;
    logic [SW-1:0] g;
    logic [SW-1:0] h;
    logic [SW-1:0] f;
    logic [SW-1:0] gkk;
  } sei_cfg_t;

endpackage

### rtl/sei_cfg.sv
// configuration registers and the derived profile constants g, h and f
// depends on sei_pkg
module sei_cfg import sei_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FW-1:0]        cfg_data_i,
  output sei_cfg_t             cfg_o
);

  logic [FW-1:0]    accel_q;
  logic [FW-1:0]    decel_q;
  logic [FW-1:0]    k1c;
  logic [FW-1:0]    k2c;
  logic [FW-1:0]    k2m;
  logic [QW-1:0]    k1s;
  logic [QW-1:0]    k2s;
  logic [QW+CW-1:0] g_prod;
  logic [QW+CW-1:0] h_prod;
  logic [SW-1:0]    g;
  logic [SW-1:0]    h;
  logic [SW-1:0]    gkk;
  sei_cfg_t         cfg_d;
  sei_cfg_t         cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= '0;
      decel_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ACCEL_END:   accel_q <= cfg_data_i;
        CFG_DECEL_START: decel_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // clamp to one and order the break points
  assign k1c = (accel_q > ONE) ? ONE : accel_q;
  assign k2c = (decel_q > ONE) ? ONE : decel_q;
  assign k2m = (k2c < k1c) ? k1c : k2c;
  assign k1s = QW'(k1c) << (Q - FRAC_BITS);
  assign k2s = QW'(k2m) << (Q - FRAC_BITS);

  // phase lengths scaled by 2/pi
  assign g_prod = (QW+CW)'(k1s) * (QW+CW)'(TWO_OVER_PI);
  assign h_prod = (QW+CW)'(QONE - k2s) * (QW+CW)'(TWO_OVER_PI);
  assign g      = SW'(g_prod >> Q);
  assign h      = SW'(h_prod >> Q);
  assign gkk    = g + SW'(k2s - k1s);

  always_comb begin
    cfg_d     = '0;
    cfg_d.k1  = k1c;
    cfg_d.k2  = k2m;
    cfg_d.k1s = k1s;
    cfg_d.g   = g;
    cfg_d.h   = h;
    cfg_d.gkk = gkk;
    cfg_d.f   = gkk + h;
  end

  // derived values, refreshed every cycle
  always_ff @(posedge clk_i) begin
    cfg_q <= cfg_d;
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/sei_div_frac.sv
// pipelined restoring divider giving (num << 30) / den for num <= den
// depends on sei_pkg
module sei_div_frac import sei_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [FW-1:0] num_i,
  input  logic [FW-1:0] den_i,
  input  sei_side_t     side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output sei_side_t     side_o
);

  localparam int unsigned RW = FW + 1;

  logic          valid_q [DIV_STG];
  logic [QW-1:0] quo_q   [DIV_STG];
  sei_side_t     side_q  [DIV_STG];
  logic [RW-1:0] rem_q   [DIV_STG-1];
  logic [FW-1:0] den_q   [DIV_STG-1];

  for (genvar st = 0; st < DIV_STG; st++) begin : g_stg
    logic          valid_in;
    logic [RW-1:0] rem_in;
    logic [QW-1:0] quo_in;
    logic [FW-1:0] den_in;
    sei_side_t     side_in;
    logic [RW-1:0] rem_n;
    logic [QW-1:0] quo_n;

    // stage source
    if (st == 0) begin : g_src
      assign valid_in = valid_i;
      assign rem_in   = RW'(num_i);
      assign quo_in   = '0;
      assign den_in   = den_i;
      assign side_in  = side_i;
    end else begin : g_src
      assign valid_in = valid_q[st-1];
      assign rem_in   = rem_q[st-1];
      assign quo_in   = quo_q[st-1];
      assign den_in   = den_q[st-1];
      assign side_in  = side_q[st-1];
    end

    // compare and subtract steps of this stage
    always_comb begin
      logic [RW-1:0] r;
      logic [QW-1:0] qv;
      r  = rem_in;
      qv = quo_in;
      for (int s = 0; s < DIV_SPS; s++) begin
        if (st * DIV_SPS + s < DIV_STEPS) begin
          if (r >= RW'(den_in)) begin
            r  = r - RW'(den_in);
            qv = {qv[QW-2:0], 1'b1};
          end else begin
            qv = {qv[QW-2:0], 1'b0};
          end
          r = {r[RW-2:0], 1'b0};
        end
      end
      rem_n = r;
      quo_n = qv;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[st] <= 1'b0;
      end else if (en_i) begin
        valid_q[st] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[st]  <= quo_n;
        side_q[st] <= side_in;
      end
    end

    // partial remainder only needed by later stages
    if (st < DIV_STG - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[st] <= rem_n;
          den_q[st] <= den_in;
        end
      end
    end
  end

  assign valid_o = valid_q[DIV_STG-1];
  assign quo_o   = quo_q[DIV_STG-1];
  assign side_o  = side_q[DIV_STG-1];

endmodule

### rtl/sei_sine.sv
// pipelined sin(u*pi/2) in q30 by horner evaluation, one multiply per stage
// depends on sei_pkg
module sei_sine import sei_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [QW-1:0] arg_i,
  input  sei_side_t     side_i,
  output logic          valid_o,
  output logic [QW-1:0] sin_o,
  output sei_side_t     side_o
);

  logic          valid_q [SIN_STG];
  logic [QW-1:0] p_q     [SIN_STG];
  sei_side_t     side_q  [SIN_STG];
  logic [QW-1:0] a_q     [SIN_STG-1];
  logic [QW-1:0] u2_q    [SIN_STG-1];

  for (genvar st = 0; st < SIN_STG; st++) begin : g_stg
    logic          valid_in;
    sei_side_t     side_in;
    logic [QW-1:0] p_n;

    if (st == 0) begin : g_op
      // clamp the argument and square it
      logic [QW-1:0]   a_c;
      logic [2*QW-1:0] sq;
      assign valid_in = valid_i;
      assign side_in  = side_i;
      assign a_c      = (arg_i > QONE) ? QONE : arg_i;
      assign sq       = (2*QW)'(a_c) * (2*QW)'(a_c);
      assign p_n      = SIN_COEF[SIN_TERMS-1];
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          a_q[st]  <= a_c;
          u2_q[st] <= QW'(sq >> Q);
        end
      end
    end else if (st == SIN_STG - 1) begin : g_op
      // final multiply by u, clamp to one
      logic [2*QW-1:0] pr;
      logic [QW-1:0]   pm;
      assign valid_in = valid_q[st-1];
      assign side_in  = side_q[st-1];
      assign pr       = (2*QW)'(a_q[st-1]) * (2*QW)'(p_q[st-1]);
      assign pm       = QW'(pr >> Q);
      assign p_n      = (pm > QONE) ? QONE : pm;
    end else begin : g_op
      // horner step with floor at zero
      logic [2*QW-1:0] pr;
      logic [QW-1:0]   m;
      logic [QW-1:0]   c;
      assign valid_in = valid_q[st-1];
      assign side_in  = side_q[st-1];
      assign c        = SIN_COEF[SIN_TERMS-1-st];
      assign pr       = (2*QW)'(u2_q[st-1]) * (2*QW)'(p_q[st-1]);
      assign m        = QW'(pr >> Q);
      assign p_n      = (m > c) ? '0 : (c - m);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          a_q[st]  <= a_q[st-1];
          u2_q[st] <= u2_q[st-1];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[st] <= 1'b0;
      end else if (en_i) begin
        valid_q[st] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        p_q[st]    <= p_n;
        side_q[st] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[SIN_STG-1];
  assign sin_o   = p_q[SIN_STG-1];
  assign side_o  = side_q[SIN_STG-1];

endmodule

### rtl/sei_div_fin.sv
// pipelined restoring divider for the final normalisation num / f
// depends on sei_pkg
module sei_div_fin import sei_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [SW-1:0] den_i,
  input  logic          force_i,
  output logic          valid_o,
  output logic [FW-1:0] quo_o,
  output logic          force_o
);

  logic          valid_q [FIN_STG];
  logic [FW-1:0] quo_q   [FIN_STG];
  logic          force_q [FIN_STG];
  logic [SW-1:0] rem_q   [FIN_STG-1];
  logic [FW-1:0] low_q   [FIN_STG-1];

  for (genvar st = 0; st < FIN_STG; st++) begin : g_stg
    logic          valid_in;
    logic          force_in;
    logic [SW-1:0] rem_in;
    logic [FW-1:0] low_in;
    logic [FW-1:0] quo_in;
    logic [SW-1:0] rem_n;
    logic [FW-1:0] quo_n;

    // stage source
    if (st == 0) begin : g_src
      assign valid_in = valid_i;
      assign force_in = force_i;
      assign rem_in   = SW'(num_i[NW-1:FW]);
      assign low_in   = num_i[FW-1:0];
      assign quo_in   = '0;
    end else begin : g_src
      assign valid_in = valid_q[st-1];
      assign force_in = force_q[st-1];
      assign rem_in   = rem_q[st-1];
      assign low_in   = low_q[st-1];
      assign quo_in   = quo_q[st-1];
    end

    // bring down one dividend bit per step
    always_comb begin
      logic [SW:0]   rr;
      logic [SW-1:0] r;
      logic [FW-1:0] qv;
      r  = rem_in;
      qv = quo_in;
      rr = '0;
      for (int s = 0; s < FIN_SPS; s++) begin
        if (st * FIN_SPS + s < FIN_STEPS) begin
          rr = {r, low_in[FW-1-(st*FIN_SPS+s)]};
          if (rr >= {1'b0, den_i}) begin
            rr = rr - {1'b0, den_i};
            qv = {qv[FW-2:0], 1'b1};
          end else begin
            qv = {qv[FW-2:0], 1'b0};
          end
          r = rr[SW-1:0];
        end
      end
      rem_n = r;
      quo_n = qv;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[st] <= 1'b0;
      end else if (en_i) begin
        valid_q[st] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[st]   <= quo_n;
        force_q[st] <= force_in;
      end
    end

    if (st < FIN_STG - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[st] <= rem_n;
          low_q[st] <= low_in;
        end
      end
    end
  end

  assign valid_o = valid_q[FIN_STG-1];
  assign quo_o   = quo_q[FIN_STG-1];
  assign force_o = force_q[FIN_STG-1];

endmodule

### rtl/sine_ease_in_out_profile.sv
// top level of the sinusoidal ease-in / ease-out motion profile
// depends on sei_pkg, sei_cfg, sei_div_frac, sei_sine and sei_div_fin
//
//   channel  direction  handshake               payload
//   in       sink       in_valid_i/in_stall_o   time_frac_i
//   out      source     out_valid_o/out_stall_i distance_frac_o
//   cfg      sink       cfg_we_i                cfg_idx_i, cfg_data_i
//
// one beat is taken every cycle unless a valid output beat is stalled;
// at 16 fraction bits: input register, 8 divider stages, 8 sine stages,
// product, sum, 9 normalising divider stages, output register
// the pipeline advances together; a stalled valid output holds every stage
// reset clears the cfg registers and all valid bits, no clearing pass

module sine_ease_in_out_profile import sei_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [FW-1:0]        cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [FW-1:0]        time_frac_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [FW-1:0]        distance_frac_o
);

  sei_cfg_t         cfg;
  logic             en;

  logic             v0_q;
  logic [FW-1:0]    t0_q;
  logic [FW-1:0]    tc;
  logic [FW-1:0]    dnum;
  logic [FW-1:0]    dden;
  sei_side_t        side0;

  logic             dv_valid;
  logic [QW-1:0]    dv_quo;
  sei_side_t        dv_side;
  logic [QW-1:0]    sin_arg;

  logic             sn_valid;
  logic [QW-1:0]    sn_val;
  sei_side_t        sn_side;
  logic [SW-1:0]    mul_a;
  logic [QW-1:0]    mul_b;
  logic [SW+QW-1:0] prod;

  logic             vp_q;
  logic [SW-1:0]    prod_q;
  sei_side_t        side_p_q;
  logic [SW-1:0]    s_sum;

  logic             vn_q;
  logic [NW-1:0]    num_q;
  logic             force_q;

  logic             fn_valid;
  logic [FW-1:0]    fn_quo;
  logic             fn_force;

  logic             out_valid_q;
  logic [FW-1:0]    dist_q;

  // configuration
  sei_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // global advance: move unless a finished beat is held at the output
  assign en         = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ~en;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_q <= time_frac_i;
    end
  end

  // phase select and divider operands
  assign tc = (t0_q > ONE) ? ONE : t0_q;

  always_comb begin
    side0.t     = tc;
    side0.phase = PH_LINEAR;
    dnum        = '0;
    dden        = FW'(1);
    if (tc < cfg.k1) begin
      side0.phase = PH_EASE_IN;
      dnum        = tc;
      dden        = cfg.k1;
    end else if (tc < cfg.k2) begin
      side0.phase = PH_LINEAR;
    end else if (cfg.k2 >= ONE) begin
      side0.phase = PH_END;
    end else begin
      side0.phase = PH_EASE_OUT;
      dnum        = tc - cfg.k2;
      dden        = ONE - cfg.k2;
    end
  end

  sei_div_frac u_div_frac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .num_i   (dnum),
    .den_i   (dden),
    .side_i  (side0),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  // ease-in mirrors the sine argument
  assign sin_arg = (dv_side.phase == PH_EASE_IN) ? (QONE - dv_quo) : dv_quo;

  sei_sine u_sine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_valid),
    .arg_i   (sin_arg),
    .side_i  (dv_side),
    .valid_o (sn_valid),
    .sin_o   (sn_val),
    .side_o  (sn_side)
  );

  // scale the sine by the phase length
  assign mul_a = (sn_side.phase == PH_EASE_IN) ? cfg.g : cfg.h;
  assign mul_b = (sn_side.phase == PH_EASE_IN) ? (QONE - sn_val) : sn_val;
  assign prod  = (SW+QW)'(mul_a) * (SW+QW)'(mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= sn_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q   <= SW'(prod >> Q);
      side_p_q <= sn_side;
    end
  end

  // distance travelled in q30
  always_comb begin
    case (side_p_q.phase)
      PH_EASE_IN:  s_sum = prod_q;
      PH_EASE_OUT: s_sum = cfg.gkk + prod_q;
      PH_LINEAR:   s_sum = cfg.g + (SW'(QW'(side_p_q.t) << (Q - FRAC_BITS)) - SW'(cfg.k1s));
      default:     s_sum = '0;
    endcase
  end

  // rounded dividend for the normalisation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else if (en) begin
      vn_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q   <= (NW'(s_sum) << FRAC_BITS) + NW'(cfg.f >> 1);
      force_q <= (side_p_q.phase == PH_END);
    end
  end

  sei_div_fin u_div_fin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vn_q),
    .num_i   (num_q),
    .den_i   (cfg.f),
    .force_i (force_q),
    .valid_o (fn_valid),
    .quo_o   (fn_quo),
    .force_o (fn_force)
  );

  // output register with saturation at one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fn_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= (fn_force || (fn_quo > ONE)) ? ONE : fn_quo;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign distance_frac_o = dist_q;

endmodule
